// File: sv/crss_pkg.sv
// Shared types and constants for the chunked read segment splitter.
package crss_pkg;

	localparam int MAX_CHUNKS_DEF = 32;

	// Widths fixed by the item and register formats.
	localparam int OFS_W  = 48;
	localparam int CSZ_W  = 32;
	localparam int ADDR_W = 64;
	localparam int IDX_W  = 6;
	localparam int EIDX_W = 5;
	localparam int DIV_STEPS = OFS_W;
	localparam int CNT_W  = 6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHUNK_SIZE  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_SIZE  = 2'd1;
	localparam logic [1:0] CFG_CHUNK_COUNT = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIRST,
		ST_LOOKUP,
		ST_SEG,
		ST_SINGLE
	} state_t;

endpackage

// File: sv/crss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module crss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/chunked_read_segment_splitter_top.sv
// Top level: splits linear reads into per-chunk copy descriptors using a chunk base table.
// A load writes its table entry when in range and gives one result; a read checks its bounds,
// divides the offset by the chunk size bit-serially, splits the quotient into chunk index and
// offset, then per segment does a table read, then the output register, waiting while it is full.
// One item at a time: the next is taken only after the last result of the previous one is issued.
// Reset (arst_n low) clears the control state, the output valid and the configuration
// registers; the chunk base table is not cleared and holds undefined data until loaded.
module chunked_read_segment_splitter_top #(
	parameter int MAX_CHUNKS = crss_pkg::MAX_CHUNKS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	// Input items.
	input  logic         s_tvalid,
	output logic         s_tready,
	// read_offset[47:0], read_length[95:48], entry_index[100:96], entry_base[164:101], zero pad
	input  logic [167:0] s_tdata,
	// func[0]
	input  logic         s_tuser,
	// Result items.
	output logic         m_tvalid,
	input  logic         m_tready,
	// seg_source[63:0], seg_dest_offset[111:64], seg_length[143:112]
	output logic [143:0] m_tdata,
	// status[0]
	output logic         m_tuser,
	output logic         m_tlast
);
	import crss_pkg::*;

	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

	state_t state_q, state_d;

	logic [CSZ_W-1:0] chunk_size_q;
	logic [OFS_W-1:0] image_size_q;
	logic [IDX_W-1:0] chunk_count_q;

	logic [OFS_W-1:0]  in_offset, in_length;
	logic [EIDX_W-1:0] in_eidx;
	logic [ADDR_W-1:0] in_base;
	logic              in_func;

	logic [OFS_W-1:0]  off_q, len_q, done_q, dq_q;
	logic [CSZ_W-1:0]  rem_q, within_q, seg_len_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [IDX_W-1:0]  ci_q;
	logic              big_q, seg_last_q, err_q;

	logic [IDX_W-1:0]  load_idx;
	logic              load_in_range;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_rdata;

	logic              accept, out_free, out_seg, out_single;
	logic              bad_read, ci_ok;
	logic [CSZ_W:0]    rem_shift, rem_diff;
	logic              rem_ge;
	logic [CSZ_W-1:0]  avail;
	logic [OFS_W-1:0]  remaining;
	logic              rem_le_avail;

	logic          m_tvalid_q;
	logic [143:0]  m_tdata_q;
	logic          m_tuser_q, m_tlast_q;

	assign in_offset = s_tdata[47:0];
	assign in_length = s_tdata[95:48];
	assign in_eidx   = s_tdata[100:96];
	assign in_base   = s_tdata[164:101];
	assign in_func   = s_tuser;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign load_idx      = {1'b0, in_eidx};
	assign load_in_range = load_idx < IDX_W'(MAX_CHUNKS);

	assign bad_read = (chunk_size_q == '0) || (off_q > image_size_q)
		|| (len_q > (image_size_q - off_q));

	// One step of restoring division: shift in the next dividend bit, subtract if it fits.
	assign rem_shift = {rem_q, dq_q[OFS_W-1]};
	assign rem_diff  = rem_shift - {1'b0, chunk_size_q};
	assign rem_ge    = rem_shift >= {1'b0, chunk_size_q};

	assign ci_ok = !big_q && (ci_q < chunk_count_q) && (ci_q < IDX_W'(MAX_CHUNKS));

	assign avail        = chunk_size_q - within_q;
	assign remaining    = len_q - done_q;
	assign rem_le_avail = remaining <= {{(OFS_W-CSZ_W){1'b0}}, avail};

	crss_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_CHUNKS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_idx[AW-1:0]),
		.wdata (in_base),
		.re    (ram_re),
		.raddr (ci_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		out_seg    = 1'b0;
		out_single = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_func == FUNC_LOAD) begin
						ram_we  = load_in_range;
						state_d = ST_SINGLE;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (bad_read || (len_q == '0)) begin
					state_d = ST_SINGLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (!ci_ok) begin
					state_d = ST_SINGLE;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_SEG;
				end
			end
			ST_SEG: begin
				if (out_free) begin
					out_seg = 1'b1;
					state_d = seg_last_q ? ST_IDLE : ST_LOOKUP;
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					out_single = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q  <= '0;
			image_size_q  <= '0;
			chunk_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHUNK_SIZE:  chunk_size_q  <= cfg_data[CSZ_W-1:0];
				CFG_IMAGE_SIZE:  image_size_q  <= cfg_data[OFS_W-1:0];
				CFG_CHUNK_COUNT: chunk_count_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					off_q <= in_offset;
					len_q <= in_length;
					err_q <= STATUS_OK;
				end
			end
			ST_CHECK: begin
				err_q     <= bad_read;
				dq_q      <= off_q;
				rem_q     <= '0;
				div_cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				rem_q     <= rem_ge ? rem_diff[CSZ_W-1:0] : rem_shift[CSZ_W-1:0];
				dq_q      <= {dq_q[OFS_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			ST_FIRST: begin
				ci_q     <= dq_q[IDX_W-1:0];
				big_q    <= |dq_q[OFS_W-1:IDX_W];
				within_q <= rem_q;
				done_q   <= '0;
			end
			ST_LOOKUP: begin
				if (!ci_ok) begin
					err_q <= STATUS_ERR;
				end
				seg_len_q  <= rem_le_avail ? remaining[CSZ_W-1:0] : avail;
				seg_last_q <= rem_le_avail;
			end
			ST_SEG: begin
				if (out_free) begin
					done_q   <= done_q + {{(OFS_W-CSZ_W){1'b0}}, seg_len_q};
					within_q <= '0;
					ci_q     <= ci_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_seg || out_single) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_seg) begin
			m_tdata_q <= {seg_len_q, done_q, ram_rdata + {{(ADDR_W-CSZ_W){1'b0}}, within_q}};
			m_tuser_q <= STATUS_OK;
			m_tlast_q <= seg_last_q;
		end else if (out_single) begin
			m_tdata_q <= '0;
			m_tuser_q <= err_q;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table read and write in the same cycle");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STATUS_ERR)) |-> m_tlast)
		else $error("error result not marked last");

	a_mid_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> ((m_tdata[143:112] != '0) && (m_tuser == STATUS_OK)))
		else $error("non-final segment is empty or in error");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (div_cnt_q == '0)) |=> (state_q == ST_FIRST))
		else $error("divider did not hand over after its last step");

	a_seg_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (state_q == ST_SEG))
		else $error("table read issued outside a segment lookup");
`endif

endmodule

// File: test/crss_tb_pkg.sv
// Scoreboard for the chunked read segment splitter testbench: predicted copy descriptors.
package crss_tb_pkg;
	import crss_pkg::*;

	typedef struct {
		logic [63:0] source;
		logic [47:0] dest_offset;
		logic [31:0] length;
		logic        status;
		logic        last;
	} segment_t;

	class segment_scoreboard;
		logic [63:0] base_table [MAX_CHUNKS_DEF];
		logic [31:0] chunk_size;
		logic [47:0] image_size;
		logic [5:0]  chunk_count;
		segment_t    expected_segments [$];
		int          mismatches;
		int          checked;
		int          error_results;
		int          loads;
		int          reads;

		function new();
			chunk_size = '0;
			image_size = '0;
			chunk_count = '0;
			mismatches = 0;
			checked = 0;
			error_results = 0;
			loads = 0;
			reads = 0;
		endfunction

		function void write_register(logic [1:0] index, logic [47:0] value);
			case (index)
			CFG_CHUNK_SIZE: chunk_size = value[31:0];
			CFG_IMAGE_SIZE: image_size = value;
			CFG_CHUNK_COUNT: chunk_count = value[5:0];
			default: ;
			endcase
		endfunction

		function void push_segment(logic [63:0] source, logic [47:0] dest_offset,
				logic [31:0] length, logic status, logic last);
			segment_t seg;
			seg = '{source, dest_offset, length, status, last};
			expected_segments.push_back(seg);
		endfunction

		// Works out every descriptor that one accepted input item should produce.
		function void note_item(logic func, logic [47:0] offset, logic [47:0] length,
				logic [4:0] index, logic [63:0] base);
			logic [63:0] done;
			logic [63:0] cur;
			logic [63:0] chunk;
			logic [63:0] chunk_ofs;
			logic [63:0] avail;
			logic [63:0] n;
			bit          stop;
			if (func == FUNC_LOAD) begin
				loads++;
				base_table[index] = base;
				push_segment('0, '0, '0, STATUS_OK, 1'b1);
				return;
			end
			reads++;
			if (chunk_size == 0 || offset > image_size || length > image_size - offset) begin
				push_segment('0, '0, '0, STATUS_ERR, 1'b1);
				return;
			end
			if (length == 0) begin
				push_segment('0, '0, '0, STATUS_OK, 1'b1);
				return;
			end
			done = '0;
			stop = 1'b0;
			while (!stop && done < 64'(length)) begin
				cur = 64'(offset) + done;
				chunk = cur / 64'(chunk_size);
				chunk_ofs = cur % 64'(chunk_size);
				avail = 64'(chunk_size) - chunk_ofs;
				n = (64'(length) - done < avail) ? 64'(length) - done : avail;
				// A chunk past the valid count ends the read with an error descriptor.
				if (chunk >= 64'(chunk_count) || chunk >= MAX_CHUNKS_DEF) begin
					push_segment('0, '0, '0, STATUS_ERR, 1'b1);
					stop = 1'b1;
				end else begin
					push_segment(base_table[chunk[4:0]] + chunk_ofs, done[47:0], n[31:0],
						STATUS_OK, done + n == 64'(length));
					done += n;
				end
			end
		endfunction

		task report(string what);
			if (mismatches < 20)
				$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_segment(segment_t got);
			segment_t want;
			if (expected_segments.size() == 0) begin
				report($sformatf("result with nothing expected, source %h status %b",
					got.source, got.status));
				return;
			end
			want = expected_segments.pop_front();
			checked++;
			if (got.status == STATUS_ERR)
				error_results++;
			if (got.source !== want.source)
				report($sformatf("source %h, expected %h", got.source, want.source));
			if (got.dest_offset !== want.dest_offset)
				report($sformatf("dest offset %h, expected %h", got.dest_offset,
					want.dest_offset));
			if (got.length !== want.length)
				report($sformatf("length %h, expected %h", got.length, want.length));
			if (got.status !== want.status)
				report($sformatf("status %b, expected %b", got.status, want.status));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		endtask
	endclass

endpackage

// File: test/chunked_read_segment_splitter_top_tb.sv
// Testbench for chunked_read_segment_splitter_top: directed and random reads checked against a predictor.
module chunked_read_segment_splitter_top_tb;
	import crss_pkg::*;
	import crss_tb_pkg::*;

	localparam logic [47:0] OFS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] CSZ_MAX = 32'hFFFF_FFFF;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [47:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	segment_scoreboard sb = new();
	int          sender_gap_pct = 9;
	int          ready_stall_pct = 82;
	logic [31:0] entry_loaded;

	chunked_read_segment_splitter_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("** chunked_read_segment_splitter_top: FAILED **");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	initial begin
		segment_t got;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = '{m_tdata[63:0], m_tdata[111:64], m_tdata[143:112], m_tuser, m_tlast};
				sb.check_segment(got);
			end
		end
	end

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function logic [63:0] pick_upto(logic [63:0] bound);
		if (bound == '1)
			return rand64();
		return rand64() % (bound + 1);
	endfunction

	// Reads may only reach table entries that have been loaded, so the chunk count
	// stays within the run of loaded entries starting at index zero.
	function int loaded_prefix();
		int k;
		k = 0;
		while (k < MAX_CHUNKS_DEF && entry_loaded[k])
			k++;
		return k;
	endfunction

	task send_item(logic func, logic [47:0] offset, logic [47:0] length, logic [4:0] index,
			logic [63:0] base);
		while ($urandom_range(99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {3'b000, base, index, length, offset};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_item(func, offset, length, index, base);
		if (func == FUNC_LOAD)
			entry_loaded[index] = 1'b1;
		@(negedge clk);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.expected_segments.size() != 0)
			@(negedge clk);
	endtask

	task configure(logic [31:0] csize, logic [47:0] isize, logic [5:0] count);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHUNK_SIZE;
		cfg_data <= 48'(csize);
		sb.write_register(CFG_CHUNK_SIZE, 48'(csize));
		@(negedge clk);
		cfg_index <= CFG_IMAGE_SIZE;
		cfg_data <= isize;
		sb.write_register(CFG_IMAGE_SIZE, isize);
		@(negedge clk);
		cfg_index <= CFG_CHUNK_COUNT;
		cfg_data <= 48'(count);
		sb.write_register(CFG_CHUNK_COUNT, 48'(count));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task drive_round(int count);
		int          mode;
		logic [63:0] offset;
		logic [63:0] length;
		logic [63:0] reach;
		logic [63:0] span;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(99);
			offset = rand64() & 64'(OFS_MAX);
			length = rand64() & 64'(OFS_MAX);
			if (mode < 15) begin
				send_item(FUNC_LOAD, offset[47:0], length[47:0], 5'($urandom_range(31)),
					rand64());
			end else begin
				if (mode < 70) begin
					// Well-formed read of a few chunks, mostly inside the valid table.
					reach = 64'(sb.chunk_size) * 64'(sb.chunk_count);
					if (reach > 64'(sb.image_size))
						reach = 64'(sb.image_size);
					offset = pick_upto(reach);
					span = 64'(sb.chunk_size) * $urandom_range(1, 4) + $urandom_range(0, 3);
					if (span > 64'(sb.image_size) - offset)
						span = 64'(sb.image_size) - offset;
					length = pick_upto(span);
				end else if (mode < 76) begin
					offset = pick_upto(64'(sb.image_size));
					length = '0;
				end else if (mode < 86) begin
					// Ends exactly at the image end or one byte past it.
					offset = pick_upto(64'(sb.image_size));
					length = 64'(sb.image_size) - offset + $urandom_range(0, 1);
				end
				send_item(FUNC_READ, offset[47:0], length[47:0], 5'($urandom_range(31)),
					rand64());
			end
		end
	endtask

	initial begin
		int          k;
		logic [63:0] csize;
		logic [63:0] isize;
		int          count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHUNK_SIZE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_LOAD;
		entry_loaded = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers still at reset: a zero chunk size fails every read.
		send_item(FUNC_READ, '0, '0, '0, '0);
		send_item(FUNC_LOAD, '0, '0, 5'd0, 64'd0);
		send_item(FUNC_LOAD, OFS_MAX, OFS_MAX, 5'd1, '1);
		send_item(FUNC_LOAD, '0, '0, 5'd2, 64'h8000_0000_0000_0000);
		for (k = 3; k < 8; k++)
			send_item(FUNC_LOAD, '0, '0, k[4:0], rand64());
		send_item(FUNC_LOAD, '0, '0, 5'd31, rand64());
		drain();

		configure(32'd16, 48'd200, 6'd8);
		send_item(FUNC_READ, 48'd0, 48'd0, '0, '0);
		send_item(FUNC_READ, 48'd5, 48'd40, '1, '1);
		// Starts inside the chunk whose base is all ones, so the source address wraps.
		send_item(FUNC_READ, 48'd20, 48'd4, '0, '0);
		send_item(FUNC_READ, 48'd100, 48'd60, '0, '0);
		send_item(FUNC_READ, 48'd200, 48'd0, '0, '0);
		send_item(FUNC_READ, 48'd201, 48'd0, '0, '0);
		send_item(FUNC_READ, 48'd150, 48'd51, '0, '0);
		send_item(FUNC_READ, 48'd0, 48'd128, '0, '0);
		drain();

		configure(CSZ_MAX, OFS_MAX, 6'd8);
		send_item(FUNC_READ, 48'd0, OFS_MAX, '0, '0);
		send_item(FUNC_READ, OFS_MAX, 48'd0, '0, '0);
		send_item(FUNC_READ, OFS_MAX, 48'd1, '0, '0);
		send_item(FUNC_LOAD, '0, '0, 5'd5, rand64());

		for (int r = 0; r < 8; r++) begin
			if (r == 3) begin
				sender_gap_pct = 82;
				ready_stall_pct = 9;
				for (k = 0; k < MAX_CHUNKS_DEF; k++)
					if (!entry_loaded[k])
						send_item(FUNC_LOAD, rand64(), rand64(), k[4:0], rand64());
			end else if (r == 6) begin
				sender_gap_pct = 0;
				ready_stall_pct = 0;
			end
			drain();
			case (r)
			0: begin
				csize = 64'd1;
				isize = $urandom_range(0, 40);
				count = $urandom_range(0, loaded_prefix());
			end
			1: begin
				csize = $urandom_range(2, 64);
				isize = csize * $urandom_range(1, 40) + $urandom_range(0, csize[31:0]);
				count = $urandom_range(0, loaded_prefix());
			end
			2: begin
				csize = '0;
				isize = rand64();
				count = loaded_prefix();
			end
			3: begin
				csize = 64'(CSZ_MAX);
				isize = 64'(OFS_MAX);
				count = 63;
			end
			4: begin
				csize = $urandom;
				isize = rand64();
				count = MAX_CHUNKS_DEF;
			end
			5: begin
				csize = $urandom_range(1, 4096);
				isize = '0;
				count = $urandom_range(0, 63);
			end
			6: begin
				csize = $urandom_range(1, 256);
				isize = csize * 33 + $urandom_range(0, csize[31:0]);
				count = $urandom_range(20, 40);
			end
			default: begin
				csize = $urandom_range(1, 1 << 20);
				isize = pick_upto(csize * 40);
				count = $urandom_range(0, 63);
			end
			endcase
			configure(csize[31:0], isize[47:0], 6'(count));
			drive_round(45);
		end

		drain();
		repeat (150) @(negedge clk);
		$display("Run covered %0d load and %0d read items; %0d descriptors checked, %0d of them errors.",
			sb.loads, sb.reads, sb.checked, sb.error_results);
		$display("Chunk sizes ranged from zero to the 32-bit maximum, images from empty to 48 bits.");
		if (sb.mismatches == 0)
			$display("** chunked_read_segment_splitter_top: PASSED **");
		else
			$display("** chunked_read_segment_splitter_top: FAILED **");
		$finish;
	end

endmodule

// File: chunked_read_segment_splitter_top.f
sv/crss_pkg.sv
sv/crss_ram.sv
sv/chunked_read_segment_splitter_top.sv
test/crss_tb_pkg.sv
test/chunked_read_segment_splitter_top_tb.sv
